### rtl/epanechnikov_kernel_summation_8x4_top_macros.svh
// Assertion macros for the Epanechnikov kernel summation block.
// Expects signals named clk and rst_n in the scope of use.
`ifndef EPANECHNIKOV_KERNEL_SUMMATION_8X4_TOP_MACROS_SVH
`define EPANECHNIKOV_KERNEL_SUMMATION_8X4_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EKM_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("ekm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EKM_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("ekm: next-cycle check failed");

`endif

### rtl/ekm_pkg.sv
// Shared types, sizes and codes for the Epanechnikov kernel summation block.
// No dependencies; the top level, ekm_dot, ekm_kern, ekm_seq and the checker import it.
`timescale 1ns / 1ps

package ekm_pkg;

    // Array geometry.
    localparam int MAX_DIM     = 64;
    localparam int SOURCE_ROWS = 8;
    localparam int TARGET_COLS = 4;

    // Fixed field widths.
    localparam int CMD_W   = 3;
    localparam int ROW_W   = 3;
    localparam int DIMF_W  = 6;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 7;
    localparam int FRAC_W  = 16;
    localparam int ONE_Q   = 65536;

    // Derived sizes.
    localparam int SRC_DEPTH = SOURCE_ROWS * MAX_DIM;
    localparam int TGT_DEPTH = TARGET_COLS * MAX_DIM;
    localparam int SRC_AW    = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
    localparam int TGT_AW    = (TGT_DEPTH > 1) ? $clog2(TGT_DEPTH) : 1;
    localparam int I_W       = (SOURCE_ROWS > 1) ? $clog2(SOURCE_ROWS) : 1;
    localparam int J_W       = (TARGET_COLS > 1) ? $clog2(TARGET_COLS) : 1;
    localparam int P_W       = $clog2(MAX_DIM + 1);

    // Datapath widths.
    localparam int PROD_W  = 2 * VAL_W;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int DOT_W   = TERM_W + P_W;
    localparam int D_W     = DOT_W + 3;
    localparam int CL_W    = $clog2(ONE_Q) + 1;
    localparam int KERN_W  = CL_W;
    localparam int WPROD_W = VAL_W + KERN_W;
    localparam int WTERM_W = WPROD_W - FRAC_W;
    localparam int ACC_W   = VAL_W + $clog2(TARGET_COLS + 1) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A = 3'd0,
        CMD_LOAD_B = 3'd1,
        CMD_NORM_A = 3'd2,
        CMD_NORM_B = 3'd3,
        CMD_WEIGHT = 3'd4,
        CMD_POT    = 3'd5,
        CMD_RUN    = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_DOT,
        ST_DRAIN,
        ST_DIST,
        ST_WMUL,
        ST_ACC,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [ROW_W-1:0]        row;
        logic [DIMF_W-1:0]       dim;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic signed [VAL_W-1:0] potential_out;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic           issue;
        logic           row_init;
        logic           dot_clear;
        logic           dist_en;
        logic           wmul_en;
        logic           acc_en;
        logic           out_en;
        logic [I_W-1:0] i;
        logic [J_W-1:0] j;
        logic [P_W-1:0] p;
    } ctrl_t;

endpackage

### rtl/epanechnikov_kernel_summation_8x4_top.sv
// Top level of the Epanechnikov kernel summation block (8 source by 4 target points).
// Depends on ekm_pkg, ekm_ram, ekm_dot, ekm_kern, ekm_seq and the assertion macro header.
`timescale 1ns / 1ps

//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+-----------------------------
//  command  | start, busy (taken: start&!busy) | item   (ekm_pkg::item_t)
//  result   | result_valid, one cycle, no stall | result (ekm_pkg::result_t)
//  config   | cfg_we, single register          | cfg_data (dims_in_use)
//
// A load beat leaves busy low, so loads stream one per cycle while no run is going.
// A run beat raises busy for the whole run; K below is dims_in_use limited to 64.
// The coordinate loop reads one coordinate pair per cycle from the two coordinate
// RAMs, so K sets the run length. Each source row ends with one result beat, and
// the eighth carries last. A new beat may be started in the cycle the last result
// is shown. Reset is asynchronous and active low; the stores hold no defined
// value until loaded. The receiver cannot stall results.

module epanechnikov_kernel_summation_8x4_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ekm_pkg::item_t              item,
    output logic                        result_valid,
    output ekm_pkg::result_t            result,
    input  logic                        cfg_we,
    input  logic [ekm_pkg::CFG_W-1:0]   cfg_data
);
    import ekm_pkg::*;

`include "epanechnikov_kernel_summation_8x4_top_macros.svh"

    // Configuration register: number of coordinates used in the inner products.
    logic [CFG_W-1:0] dims_reg;
    logic [P_W-1:0]   kdims;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            dims_reg <= cfg_data;
        end
    end

    // Anything above the array depth is treated as the full depth.
    assign kdims = (32'(dims_reg) > MAX_DIM) ? P_W'(MAX_DIM) : P_W'(dims_reg);

    // Command decode. Loads complete in the beat they are accepted.
    logic accept;
    logic run_go;
    logic src_row_ok;
    logic tgt_row_ok;
    logic dim_ok;

    assign accept     = start && !busy;
    assign run_go     = accept && (item.command == CMD_RUN);
    assign src_row_ok = (32'(item.row) < SOURCE_ROWS);
    assign tgt_row_ok = (32'(item.row) < TARGET_COLS);
    assign dim_ok     = (32'(item.dim) < MAX_DIM);

    // Sequencer.
    ctrl_t ctrl;
    logic  pipe_busy;

    ekm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_go    (run_go),
        .kdims     (kdims),
        .pipe_busy (pipe_busy),
        .ctrl      (ctrl),
        .busy      (busy)
    );

    // Coordinate RAMs, row-major: entry = point * MAX_DIM + coordinate.
    logic              src_we;
    logic              tgt_we;
    logic [SRC_AW-1:0] src_waddr;
    logic [TGT_AW-1:0] tgt_waddr;
    logic [SRC_AW-1:0] src_raddr;
    logic [TGT_AW-1:0] tgt_raddr;
    logic [VAL_W-1:0]  src_rdata;
    logic [VAL_W-1:0]  tgt_rdata;

    assign src_we    = accept && (item.command == CMD_LOAD_A) && src_row_ok && dim_ok;
    assign tgt_we    = accept && (item.command == CMD_LOAD_B) && tgt_row_ok && dim_ok;
    assign src_waddr = SRC_AW'(item.row) * SRC_AW'(MAX_DIM) + SRC_AW'(item.dim);
    assign tgt_waddr = TGT_AW'(item.row) * TGT_AW'(MAX_DIM) + TGT_AW'(item.dim);
    assign src_raddr = SRC_AW'(ctrl.i) * SRC_AW'(MAX_DIM) + SRC_AW'(ctrl.p);
    assign tgt_raddr = TGT_AW'(ctrl.j) * TGT_AW'(MAX_DIM) + TGT_AW'(ctrl.p);

    ekm_ram #(
        .DEPTH (SRC_DEPTH),
        .WIDTH (VAL_W)
    ) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (src_waddr),
        .wdata (item.value),
        .re    (ctrl.issue),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    ekm_ram #(
        .DEPTH (TGT_DEPTH),
        .WIDTH (VAL_W)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (tgt_waddr),
        .wdata (item.value),
        .re    (ctrl.issue),
        .raddr (tgt_raddr),
        .rdata (tgt_rdata)
    );

    // Inner product of the current source row and target column.
    logic signed [DOT_W-1:0] dot;

    ekm_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (ctrl.issue),
        .clear     (ctrl.dot_clear),
        .a_data    ($signed(src_rdata)),
        .b_data    ($signed(tgt_rdata)),
        .dot       (dot),
        .pipe_busy (pipe_busy)
    );

    // Small stores. Each is read at one place, indexed by the sequencer.
    logic signed [VAL_W-1:0] src_norm   [SOURCE_ROWS];
    logic signed [VAL_W-1:0] tgt_norm   [TARGET_COLS];
    logic signed [VAL_W-1:0] tgt_weight [TARGET_COLS];
    logic signed [VAL_W-1:0] potential  [SOURCE_ROWS];
    logic signed [VAL_W-1:0] pot_sat;

    always_ff @(posedge clk)
    begin
        if (accept && (item.command == CMD_NORM_A) && src_row_ok)
        begin
            src_norm[item.row[I_W-1:0]] <= item.value;
        end
        if (accept && (item.command == CMD_NORM_B) && tgt_row_ok)
        begin
            tgt_norm[item.row[J_W-1:0]] <= item.value;
        end
        if (accept && (item.command == CMD_WEIGHT) && tgt_row_ok)
        begin
            tgt_weight[item.row[J_W-1:0]] <= item.value;
        end
        // A run writes back the updated potential as the row finishes.
        if (ctrl.out_en)
        begin
            potential[ctrl.i] <= pot_sat;
        end
        else if (accept && (item.command == CMD_POT) && src_row_ok)
        begin
            potential[item.row[I_W-1:0]] <= item.value;
        end
    end

    ekm_kern u_kern (
        .clk      (clk),
        .ctrl     (ctrl),
        .dot      (dot),
        .aa       (src_norm[ctrl.i]),
        .bb       (tgt_norm[ctrl.j]),
        .weight   (tgt_weight[ctrl.j]),
        .pot_init (potential[ctrl.i]),
        .pot_sat  (pot_sat)
    );

    // Result register: one beat per finished row.
    logic    result_valid_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= ctrl.out_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_en)
        begin
            result_reg.out_row       <= ROW_W'(ctrl.i);
            result_reg.potential_out <= pot_sat;
            result_reg.last          <= (ctrl.i == I_W'(SOURCE_ROWS - 1));
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The last result of a run coincides with the sequencer going idle.
    `EKM_ASSERT_NOW(a_last_ends_run, result_valid && result.last, !busy)
    // Any other result leaves the run going.
    `EKM_ASSERT_NOW(a_mid_result_busy, result_valid && !result.last, busy)
    // An accepted run beat makes the block busy.
    `EKM_ASSERT_NEXT(a_run_starts, start && !busy && item.command == CMD_RUN, busy)
    // A load beat never starts the sequencer.
    `EKM_ASSERT_NEXT(a_load_stays_idle, start && !busy && item.command != CMD_RUN, !busy)

endmodule

### rtl/ekm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ekm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ekm_dot.sv
// Inner-product pipeline: multiply stage, then floor back to Q32.16 and accumulate.
// Depends on ekm_pkg; fed by the two coordinate RAMs.
`timescale 1ns / 1ps

module ekm_dot (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               issue,
    input  logic                               clear,
    input  logic signed [ekm_pkg::VAL_W-1:0]   a_data,
    input  logic signed [ekm_pkg::VAL_W-1:0]   b_data,
    output logic signed [ekm_pkg::DOT_W-1:0]   dot,
    output logic                               pipe_busy
);
    import ekm_pkg::*;

    logic                     rd_valid_reg;
    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [TERM_W-1:0] term;
    logic signed [DOT_W-1:0]  dot_next;
    logic signed [DOT_W-1:0]  dot_reg;

    // RAM data lands in the cycle after the read is issued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    assign prod_next = PROD_W'(a_data) * PROD_W'(b_data);
    // Dropping the low fraction bits of a two's complement value is a floor.
    assign term      = prod_reg[PROD_W-1:FRAC_W];

    always_comb
    begin
        dot_next = dot_reg;
        if (clear)
        begin
            dot_next = '0;
        end
        else if (prod_valid_reg)
        begin
            dot_next = dot_reg + DOT_W'(term);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        dot_reg  <= dot_next;
    end

    assign dot       = dot_reg;
    assign pipe_busy = rd_valid_reg | prod_valid_reg;

endmodule

### rtl/ekm_kern.sv
// Distance clamp, 3/4 kernel, weight multiply and per-row potential sum.
// Depends on ekm_pkg; driven by the sequencer control struct.
`timescale 1ns / 1ps

module ekm_kern (
    input  logic                               clk,
    input  ekm_pkg::ctrl_t                     ctrl,
    input  logic signed [ekm_pkg::DOT_W-1:0]   dot,
    input  logic signed [ekm_pkg::VAL_W-1:0]   aa,
    input  logic signed [ekm_pkg::VAL_W-1:0]   bb,
    input  logic signed [ekm_pkg::VAL_W-1:0]   weight,
    input  logic signed [ekm_pkg::VAL_W-1:0]   pot_init,
    output logic signed [ekm_pkg::VAL_W-1:0]   pot_sat
);
    import ekm_pkg::*;

    logic signed [D_W-1:0]     d_full;
    logic [CL_W-1:0]           d_cl;
    logic [CL_W-1:0]           diff;
    logic [CL_W:0]             diff3;
    logic signed [KERN_W-1:0]  kern_next;
    logic signed [KERN_W-1:0]  kern_reg;
    logic signed [WPROD_W-1:0] wprod_next;
    logic signed [WPROD_W-1:0] wprod_reg;
    logic signed [WTERM_W-1:0] wterm;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [ACC_W-VAL_W:0]      acc_top;

    // Squared distance, clamped to the range zero to one.
    assign d_full = D_W'(aa) + D_W'(bb) - (D_W'(dot) <<< 1);

    always_comb
    begin
        if (d_full[D_W-1])
        begin
            d_cl = '0;
        end
        else if (d_full > D_W'(ONE_Q))
        begin
            d_cl = CL_W'(ONE_Q);
        end
        else
        begin
            d_cl = d_full[CL_W-1:0];
        end
    end

    // Three quarters of (one minus d), floored.
    assign diff      = CL_W'(ONE_Q) - d_cl;
    assign diff3     = {diff, 1'b0} + (CL_W + 1)'(diff);
    assign kern_next = KERN_W'(diff3[CL_W:2]);

    assign wprod_next = WPROD_W'(weight) * WPROD_W'(kern_reg);
    assign wterm      = wprod_reg[WPROD_W-1:FRAC_W];

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.row_init)
        begin
            acc_next = ACC_W'(pot_init);
        end
        else if (ctrl.acc_en)
        begin
            acc_next = acc_reg + ACC_W'(wterm);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.dist_en)
        begin
            kern_reg <= kern_next;
        end
        if (ctrl.wmul_en)
        begin
            wprod_reg <= wprod_next;
        end
        acc_reg <= acc_next;
    end

    // Saturate once to the signed 32-bit range.
    assign acc_top = acc_reg[ACC_W-1:VAL_W-1];

    always_comb
    begin
        if (acc_top == '0 || acc_top == '1)
        begin
            pot_sat = acc_reg[VAL_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            pot_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            pot_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

endmodule

### rtl/ekm_seq.sv
// Run sequencer: walks source rows, target columns and coordinates.
// Depends on ekm_pkg; drives the RAM reads and the arithmetic units.
`timescale 1ns / 1ps

module ekm_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        run_go,
    input  logic [ekm_pkg::P_W-1:0]     kdims,
    input  logic                        pipe_busy,
    output ekm_pkg::ctrl_t              ctrl,
    output logic                        busy
);
    import ekm_pkg::*;

    seq_state_t     state_reg;
    seq_state_t     state_next;
    logic [I_W-1:0] i_reg;
    logic [I_W-1:0] i_next;
    logic [J_W-1:0] j_reg;
    logic [J_W-1:0] j_next;
    logic [P_W-1:0] p_reg;
    logic [P_W-1:0] p_next;
    logic [P_W:0]   p_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
        end
    end

    assign p_inc = (P_W + 1)'(p_reg) + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        p_next         = p_reg;
        ctrl           = '0;
        ctrl.i         = i_reg;
        ctrl.j         = j_reg;
        ctrl.p         = p_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (run_go)
                begin
                    i_next     = '0;
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                ctrl.row_init  = 1'b1;
                ctrl.dot_clear = 1'b1;
                j_next         = '0;
                p_next         = '0;
                state_next     = ST_DOT;
            end
            ST_DOT:
            begin
                ctrl.issue = (p_reg < kdims);
                p_next     = p_inc[P_W-1:0];
                if (p_inc >= (P_W + 1)'(kdims))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_DIST;
                end
            end
            ST_DIST:
            begin
                ctrl.dist_en   = 1'b1;
                ctrl.dot_clear = 1'b1;
                state_next     = ST_WMUL;
            end
            ST_WMUL:
            begin
                ctrl.wmul_en = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                ctrl.acc_en = 1'b1;
                if (j_reg == J_W'(TARGET_COLS - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    p_next     = '0;
                    state_next = ST_DOT;
                end
            end
            ST_OUT:
            begin
                ctrl.out_en = 1'b1;
                if (i_reg == I_W'(SOURCE_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ROW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### tb/sv/ekm_potential_checker.sv
// Result checker for the Epanechnikov kernel summation block: tracks loads and the
// dims_in_use register, predicts every potential beat of a run and compares them.
// Depends on ekm_pkg for the beat types, command codes and array sizes.
`timescale 1ns / 1ps

module ekm_potential_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  ekm_pkg::item_t                item,
    input  logic                          result_valid,
    input  ekm_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [ekm_pkg::CFG_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            results_due
);
    import ekm_pkg::*;

    localparam longint POT_MAX = 64'sd2147483647;
    localparam longint POT_MIN = -64'sd2147483648;

    // Shadow copy of the block's stores and its one register.
    logic signed [VAL_W-1:0] src_coord [SOURCE_ROWS][MAX_DIM];
    logic signed [VAL_W-1:0] tgt_coord [TARGET_COLS][MAX_DIM];
    logic signed [VAL_W-1:0] src_norm  [SOURCE_ROWS];
    logic signed [VAL_W-1:0] tgt_norm  [TARGET_COLS];
    logic signed [VAL_W-1:0] tgt_weight[TARGET_COLS];
    logic signed [VAL_W-1:0] potential [SOURCE_ROWS];
    int unsigned             dims_in_use;

    result_t                 potentials_due[$];

    task automatic report(string what, logic signed [VAL_W-1:0] want,
                          logic signed [VAL_W-1:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
    endtask

    // One run: every source row gains the weighted kernel sum over all targets.
    task automatic sweep_potentials();
        int      k;
        longint  acc;
        longint  dot;
        longint  sq_dist;
        longint  kern;
        result_t r;
        k = (dims_in_use > MAX_DIM) ? MAX_DIM : int'(dims_in_use);
        for (int i = 0; i < SOURCE_ROWS; i++)
        begin
            acc = longint'(potential[i]);
            for (int j = 0; j < TARGET_COLS; j++)
            begin
                dot = 0;
                for (int p = 0; p < k; p++)
                begin
                    dot += (longint'(src_coord[i][p]) * longint'(tgt_coord[j][p])) >>> FRAC_W;
                end
                sq_dist = longint'(src_norm[i]) + longint'(tgt_norm[j]) - 2 * dot;
                if (sq_dist < 0)
                    sq_dist = 0;
                if (sq_dist > ONE_Q)
                    sq_dist = ONE_Q;
                kern = (3 * (ONE_Q - sq_dist)) >>> 2;
                acc += (longint'(tgt_weight[j]) * kern) >>> FRAC_W;
            end
            if (acc > POT_MAX)
                acc = POT_MAX;
            if (acc < POT_MIN)
                acc = POT_MIN;
            potential[i] = acc[VAL_W-1:0];
            r.out_row = ROW_W'(i);
            r.potential_out = potential[i];
            r.last = (i == SOURCE_ROWS - 1);
            potentials_due.push_back(r);
        end
    endtask

    task automatic take_beat(item_t b);
        case (b.command)
            CMD_LOAD_A: src_coord[b.row][b.dim] = b.value;
            CMD_LOAD_B: if (b.row < TARGET_COLS) tgt_coord[b.row][b.dim] = b.value;
            CMD_NORM_A: src_norm[b.row] = b.value;
            CMD_NORM_B: if (b.row < TARGET_COLS) tgt_norm[b.row] = b.value;
            CMD_WEIGHT: if (b.row < TARGET_COLS) tgt_weight[b.row] = b.value;
            CMD_POT:    potential[b.row] = b.value;
            CMD_RUN:    sweep_potentials();
            default:    ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            dims_in_use = 1;
            potentials_due.delete();
        end
        else
        begin
            if (cfg_we)
                dims_in_use = int'(cfg_data);
            if (result_valid)
            begin
                if (potentials_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with none expected, got row %0d potential %0d",
                             $time, result.out_row, result.potential_out);
                end
                else
                begin
                    want = potentials_due.pop_front();
                    if (result.out_row !== want.out_row)
                        report("out_row", want.out_row, result.out_row);
                    if (result.potential_out !== want.potential_out)
                        report("potential_out", want.potential_out, result.potential_out);
                    if (result.last !== want.last)
                        report("last", want.last, result.last);
                end
            end
            if (start && !busy)
                take_beat(item);
        end
        results_due = potentials_due.size();
    end

endmodule

### tb/sv/tb_top.sv
// Top of the testbench for the Epanechnikov kernel summation block: clock, reset,
// command and config stimulus, watchdog and the final verdict.
// Depends on ekm_pkg, the block's top level and ekm_potential_checker.
`timescale 1ns / 1ps

module tb_top;
    import ekm_pkg::*;

    // Command 7 is not a member of cmd_t; the block must ignore it.
    localparam logic [CMD_W-1:0] CMD_NONE = 3'd7;

    // The longest legal gap between two taken beats, command or result, is one
    // source row of a run at 64 dimensions; the limit leaves ample room.
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int ITEM_BUDGET     = 140;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    item_t            item = '0;
    logic             result_valid;
    result_t          result;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_data = CFG_W'(1);

    int               mismatches;
    int               results_due;
    int               quiet_cycles = 0;

    // What the stimulus has loaded so far. A run is only issued once every
    // entry it will read holds a written value.
    bit               have_a   [SOURCE_ROWS][MAX_DIM];
    bit               have_b   [TARGET_COLS][MAX_DIM];
    bit               have_na  [SOURCE_ROWS];
    bit               have_nb  [TARGET_COLS];
    bit               have_w   [TARGET_COLS];
    bit               have_pot [SOURCE_ROWS];
    int               dims_now = 1;
    bit               gaps_on = 1'b1;
    int               items_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    epanechnikov_kernel_summation_8x4_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    ekm_potential_checker potential_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .results_due  (results_due)
    );

    // The watchdog restarts whenever a command beat or a result beat is taken.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Value generators. Coordinates of about half a unit and norms up to one and
    // a half units keep most squared distances inside the kernel's support, so
    // both the clamped and the open region of the kernel get exercised.
    function automatic logic [VAL_W-1:0] coord_val();
        return $urandom_range(0, 65536) - 32'd32768;
    endfunction

    function automatic logic [VAL_W-1:0] norm_val();
        return $urandom_range(0, 98304);
    endfunction

    function automatic logic [VAL_W-1:0] weight_val();
        return $urandom_range(0, 524288) - 32'd262144;
    endfunction

    // Potentials are mostly small; now and then they sit next to either
    // rail so that the saturation of the sum gets hit from both sides.
    function automatic logic [VAL_W-1:0] pot_val();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(0, 2097152) - 32'd1048576;
        else if ($urandom_range(0, 1) != 0)
            return 32'h7FF0_0000 + $urandom_range(0, 1048575);
        else
            return 32'h8000_0000 + $urandom_range(0, 1048575);
    endfunction

    // Drive one command beat and return at the edge that takes it. The block
    // only changes busy at a rising edge, so its value at the falling edge
    // tells whether the next rising edge accepts the beat.
    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                             logic [DIMF_W-1:0] dim, logic [VAL_W-1:0] v);
        item_t b;
        b.command = cmd;
        b.row = row;
        b.dim = dim;
        b.value = v;
        if (gaps_on && $urandom_range(0, 99) < 10)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= b;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        items_sent++;
        case (cmd)
            CMD_LOAD_A: have_a[row][dim] = 1'b1;
            CMD_LOAD_B: if (row < TARGET_COLS) have_b[row][dim] = 1'b1;
            CMD_NORM_A: have_na[row] = 1'b1;
            CMD_NORM_B: if (row < TARGET_COLS) have_nb[row] = 1'b1;
            CMD_WEIGHT: if (row < TARGET_COLS) have_w[row] = 1'b1;
            CMD_POT:    have_pot[row] = 1'b1;
            default:    ;
        endcase
    endtask

    // The register is only written with the block idle: no command held, no
    // potential beat outstanding and busy low.
    task automatic write_dims(int v);
        start <= 1'b0;
        do
            @(negedge clk);
        while (busy || results_due != 0);
        repeat (4) @(posedge clk);
        cfg_data <= CFG_W'(v);
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        dims_now = v;
    endtask

    // Fill every store entry that the next run will read and that was never
    // loaded. With dims_in_use at zero no coordinate is read at all.
    task automatic complete_operands();
        int k;
        k = (dims_now > MAX_DIM) ? MAX_DIM : dims_now;
        for (int i = 0; i < SOURCE_ROWS; i++)
        begin
            for (int p = 0; p < k; p++)
            begin
                if (!have_a[i][p])
                    send_beat(CMD_LOAD_A, ROW_W'(i), DIMF_W'(p), coord_val());
            end
            if (!have_na[i])
                send_beat(CMD_NORM_A, ROW_W'(i), '0, norm_val());
            if (!have_pot[i])
                send_beat(CMD_POT, ROW_W'(i), '0, pot_val());
        end
        for (int j = 0; j < TARGET_COLS; j++)
        begin
            for (int p = 0; p < k; p++)
            begin
                if (!have_b[j][p])
                    send_beat(CMD_LOAD_B, ROW_W'(j), DIMF_W'(p), coord_val());
            end
            if (!have_nb[j])
                send_beat(CMD_NORM_B, ROW_W'(j), '0, norm_val());
            if (!have_w[j])
                send_beat(CMD_WEIGHT, ROW_W'(j), '0, weight_val());
        end
    endtask

    // A run beat carries random row, dim and value fields, all of which the
    // block must ignore.
    task automatic run_sweep();
        complete_operands();
        send_beat(CMD_RUN, ROW_W'($urandom), DIMF_W'($urandom), $urandom);
    endtask

    // Most loads are well formed: a valid row for the store, a coordinate
    // index the current setting reads, and a value in the working range. The
    // rest are noise: any command but run, any row and dim, any value.
    task automatic random_load();
        int                k;
        logic [CMD_W-1:0]  c;
        logic [ROW_W-1:0]  r;
        logic [DIMF_W-1:0] d;
        logic [VAL_W-1:0]  v;
        k = (dims_now > MAX_DIM) ? MAX_DIM : ((dims_now == 0) ? 1 : dims_now);
        if ($urandom_range(0, 99) < 85)
        begin
            c = CMD_W'($urandom_range(CMD_LOAD_A, CMD_POT));
            if (c == CMD_LOAD_B || c == CMD_NORM_B || c == CMD_WEIGHT)
                r = ROW_W'($urandom_range(0, TARGET_COLS - 1));
            else
                r = ROW_W'($urandom_range(0, SOURCE_ROWS - 1));
            d = DIMF_W'($urandom_range(0, k - 1));
            case (c)
                CMD_LOAD_A, CMD_LOAD_B: v = coord_val();
                CMD_NORM_A, CMD_NORM_B: v = norm_val();
                CMD_WEIGHT:             v = weight_val();
                default:                v = pot_val();
            endcase
        end
        else
        begin
            c = CMD_W'($urandom_range(CMD_LOAD_A, CMD_RUN));
            if (c == CMD_RUN)
                c = CMD_NONE;
            r = ROW_W'($urandom);
            d = DIMF_W'($urandom);
            v = $urandom;
        end
        send_beat(c, r, d, v);
    endtask

    initial
    begin
        int sweeps;
        sweeps = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset setting of one dimension. Extreme
        // coordinates drive the distance far below zero, so the kernel sits at
        // its peak, and extreme weights then saturate the potentials.
        write_dims(1);
        send_beat(CMD_LOAD_A, 3'd0, 6'd0, 32'h7FFF_FFFF);
        send_beat(CMD_LOAD_A, 3'd7, 6'd63, 32'h8000_0000);
        send_beat(CMD_LOAD_A, 3'd7, 6'd0, 32'h8000_0000);
        send_beat(CMD_LOAD_B, 3'd3, 6'd0, 32'h8000_0000);
        send_beat(CMD_LOAD_B, 3'd0, 6'd0, 32'h7FFF_FFFF);
        // Loads into rows past the four target entries are dropped.
        send_beat(CMD_LOAD_B, 3'd7, 6'd5, 32'h1234_5678);
        send_beat(CMD_NORM_A, 3'd7, 6'd0, 32'h7FFF_FFFF);
        send_beat(CMD_NORM_B, 3'd4, 6'd0, 32'h0000_0001);
        send_beat(CMD_WEIGHT, 3'd0, 6'd0, 32'h7FFF_FFFF);
        send_beat(CMD_WEIGHT, 3'd1, 6'd0, 32'h8000_0000);
        send_beat(CMD_WEIGHT, 3'd6, 6'd0, 32'h0000_0005);
        send_beat(CMD_POT, 3'd0, 6'd0, 32'h7FFF_FFFF);
        send_beat(CMD_POT, 3'd1, 6'd0, 32'h8000_0000);
        send_beat(CMD_POT, 3'd2, 6'd0, 32'h0000_0000);
        // The unused command code must leave every store alone.
        send_beat(CMD_NONE, 3'd5, 6'd63, 32'hFFFF_FFFF);
        run_sweep();

        // Zero dimensions: every inner product is zero.
        write_dims(0);
        send_beat(CMD_NORM_A, 3'd3, 6'd0, 32'h0000_0000);
        send_beat(CMD_NORM_B, 3'd2, 6'd0, 32'h0001_0000);
        run_sweep();

        // Random part: phases of a few sweeps at one setting, each sweep a
        // burst of loads followed by a run. The second phase inserts no random
        // idle cycles between its command beats.
        while (items_sent < ITEM_BUDGET)
        begin
            if (sweeps % 3 == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    write_dims(0);
                else
                    write_dims($urandom_range(1, 5));
                gaps_on = (sweeps / 3 != 1);
            end
            repeat ($urandom_range(2, 10)) random_load();
            run_sweep();
            sweeps++;
        end
        gaps_on = 1'b1;

        // Back to a small setting to close.
        write_dims(2);
        repeat (6) random_load();
        run_sweep();

        // Drain: every expected potential must arrive, then let the block settle.
        start <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && results_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
